// ===== rtl/core/lhrs_pkg.sv =====
// Package: shared constants, request codes and sequencer states for the latency statistics block
`timescale 1ns / 1ps
package lhrs_pkg;

    localparam int NUM_BUCKETS_DEF  = 128;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam logic [15:0] BUCKET_WIDTH_RST = 16'd5;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 32;
    localparam int SDEV_W   = 64;
    localparam int VAR_W    = 48;
    localparam int DIV_W    = 64;
    localparam int PROD_W   = 56;
    localparam int SQRT_STEPS = 24;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_READ    = 2'd1,
        REQ_SETUP   = 2'd2,
        REQ_CLR_ALL = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BDIV,
        ST_RAM_RD,
        ST_RAM_RSP,
        ST_MMUL,
        ST_MDIV,
        ST_SQMUL,
        ST_UPD,
        ST_CLR,
        ST_VDIV,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/lhrs_ram.sv =====
// Generic single write port, single read port RAM with registered read data
`timescale 1ns / 1ps
module lhrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/lhrs_div.sv =====
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lhrs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lhrs_pkg::DIV_W-1:0]  i_num,
    input  logic [lhrs_pkg::DIV_W-1:0]  i_den,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [lhrs_pkg::DIV_W-1:0]  o_quo
);
    localparam int W   = lhrs_pkg::DIV_W;
    localparam int CW  = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_num[W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(W - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[W-2:0], 1'b0};
            r_rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/core/latency_histogram_running_stats.sv =====
// Top level: per-channel latency histogram with running mean, variance and standard deviation
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request transaction:
//   add sample, read channel and bucket, set up channel, or clear all.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per request. Configuration channel (i_cfg_valid / o_cfg_ready)
//   writes the bucket width in whole ms; it is always ready; the user must
//   write it only while the block is idle, the block does not enforce this.
//   Sequence: one request at a time. Clear all and rejected requests go
//   straight to the result. Every division runs on the shared divider
//   (launch, 64 quotient bits, finish). Every other request ends with a
//   variance division (skipped when count < 2) and a square root. An add
//   sample adds a bucket division (skipped for zero width), a RAM
//   read-modify-write, a multiply, a mean division and a deviation product
//   (these three skipped on the first sample) and an update. A read adds
//   a RAM read. A setup of a fresh channel sweeps its NUM_BUCKETS histogram
//   entries, one per cycle, before the variance step.
//   The shared divider sets the rate; one transaction is in flight at a time.
//   Reset: every channel becomes not set up, bucket width returns to 5.
//   Histogram RAM is not cleared at reset; a fresh channel's setup clears its row.
//   Stall: the result waits in the output register; the block may take the
//   next request meanwhile and holds its own result until the slot frees.
module latency_histogram_running_stats #(
    parameter int NUM_BUCKETS  = lhrs_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_CHANNELS = lhrs_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_channel,
    input  logic [23:0] i_sample,
    input  logic [6:0]  i_bucket_select,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [31:0] o_sample_count,
    output logic [23:0] o_mean,
    output logic [47:0] o_variance,
    output logic [23:0] o_std_dev,
    output logic [6:0]  o_bucket_index,
    output logic [31:0] o_bucket_count
);
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHX_W  = (CH_W > 3) ? CH_W : 3;
    localparam int BK_W   = $clog2(NUM_BUCKETS);
    localparam int BKX_W  = (BK_W > 7) ? BK_W : 7;
    localparam int AW     = $clog2(NUM_CHANNELS * NUM_BUCKETS);
    localparam int DW     = lhrs_pkg::DIV_W;
    localparam int CNT_W  = lhrs_pkg::COUNT_W;
    localparam int SMP_W  = lhrs_pkg::SAMPLE_W;
    localparam int SD_W   = lhrs_pkg::SDEV_W;
    localparam int VAR_W  = lhrs_pkg::VAR_W;
    localparam int PW     = lhrs_pkg::PROD_W;
    localparam int SQ_CW  = $clog2(lhrs_pkg::SQRT_STEPS);

    // Sequencer state and request
    lhrs_pkg::t_state r_state, n_state;
    lhrs_pkg::t_req   r_req;
    logic [CH_W-1:0]  r_ch;
    logic [SMP_W-1:0] r_x;
    logic [BK_W-1:0]  r_bkt;
    logic [CNT_W-1:0] r_bcnt;
    logic             r_zero;
    logic             r_status;
    logic [15:0]      r_bw;
    logic [BK_W-1:0]  r_clr;
    logic             r_div_issued;
    logic [SMP_W-1:0] r_nm;
    logic [PW-1:0]    r_prod;
    logic [VAR_W-1:0] r_var;
    logic [VAR_W-1:0] r_sv;
    logic [VAR_W-1:0] r_sres;
    logic [VAR_W-1:0] r_sbit;
    logic [SQ_CW-1:0] r_sk;

    // Per-channel statistics
    logic [NUM_CHANNELS-1:0] r_chv;
    logic [CNT_W-1:0] r_cnt  [NUM_CHANNELS];
    logic [SMP_W-1:0] r_mean [NUM_CHANNELS];
    logic [SD_W-1:0]  r_sdev [NUM_CHANNELS];

    // Output register
    logic             r_ov;
    logic             r_o_status;
    logic [31:0]      r_o_cnt;
    logic [23:0]      r_o_mean;
    logic [47:0]      r_o_var;
    logic [23:0]      r_o_sd;
    logic [6:0]       r_o_bidx;
    logic [31:0]      r_o_bcnt;

    logic             in_acc;
    logic [CHX_W-1:0] ch_ext;
    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [CNT_W-1:0] cur_cnt;
    logic [SMP_W-1:0] cur_mean;
    logic [SD_W-1:0]  cur_sdev;

    logic             div_start, div_busy, div_done;
    logic [DW-1:0]    div_num, div_den, div_quo;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr, ram_base;
    logic [CNT_W-1:0] ram_wdata, ram_rdata, bkt_inc;

    logic [CNT_W-1:0] mul_a;
    logic [SMP_W-1:0] mul_b;
    logic [SMP_W-1:0] d1, d2;
    logic [SD_W:0]    s_sum;
    logic [VAR_W:0]   sq_t;
    logic [BKX_W-1:0] bkt_ext;
    logic             out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign ch_ext   = CHX_W'(i_channel);
    assign ch_ok    = {1'b0, ch_ext} < (CHX_W + 1)'(NUM_CHANNELS);
    assign ch_idx   = ch_ext[CH_W-1:0];
    assign cur_cnt  = r_cnt[r_ch];
    assign cur_mean = r_mean[r_ch];
    assign cur_sdev = r_sdev[r_ch];
    assign out_free = !r_ov || i_out_ready;
    assign ram_base = AW'(r_ch * NUM_BUCKETS);
    assign bkt_inc  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    assign d1       = (r_x >= cur_mean) ? r_x - cur_mean : cur_mean - r_x;
    assign d2       = (r_x >= r_nm) ? r_x - r_nm : r_nm - r_x;
    assign s_sum    = {1'b0, cur_sdev} + (SD_W + 1)'(r_prod);
    assign sq_t     = {1'b0, r_sres} + {1'b0, r_sbit};
    assign bkt_ext  = BKX_W'(r_bkt);

    // Shared divider for bucket, mean and variance
    lhrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Histogram store, one row of NUM_BUCKETS per channel
    lhrs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CHANNELS * NUM_BUCKETS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lhrs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == lhrs_pkg::REQ_CLR_ALL || !ch_ok) begin
                        n_state = lhrs_pkg::ST_DONE;
                    end else if (i_req_type == lhrs_pkg::REQ_SETUP) begin
                        n_state = r_chv[ch_idx] ? lhrs_pkg::ST_VDIV : lhrs_pkg::ST_CLR;
                    end else if (!r_chv[ch_idx]) begin
                        n_state = lhrs_pkg::ST_DONE;
                    end else if (i_req_type == lhrs_pkg::REQ_READ || r_bw == '0) begin
                        n_state = lhrs_pkg::ST_RAM_RD;
                    end else begin
                        n_state = lhrs_pkg::ST_BDIV;
                    end
                end
            end
            lhrs_pkg::ST_BDIV:    if (div_done) n_state = lhrs_pkg::ST_RAM_RD;
            lhrs_pkg::ST_RAM_RD:  n_state = lhrs_pkg::ST_RAM_RSP;
            lhrs_pkg::ST_RAM_RSP: begin
                if (r_req == lhrs_pkg::REQ_READ) begin
                    n_state = lhrs_pkg::ST_VDIV;
                end else if (cur_cnt == '0) begin
                    n_state = lhrs_pkg::ST_UPD;
                end else begin
                    n_state = lhrs_pkg::ST_MMUL;
                end
            end
            lhrs_pkg::ST_MMUL:    n_state = lhrs_pkg::ST_MDIV;
            lhrs_pkg::ST_MDIV:    if (div_done) n_state = lhrs_pkg::ST_SQMUL;
            lhrs_pkg::ST_SQMUL:   n_state = lhrs_pkg::ST_UPD;
            lhrs_pkg::ST_UPD:     n_state = lhrs_pkg::ST_VDIV;
            lhrs_pkg::ST_CLR: begin
                if (r_clr == BK_W'(NUM_BUCKETS - 1)) n_state = lhrs_pkg::ST_VDIV;
            end
            lhrs_pkg::ST_VDIV: begin
                if (cur_cnt < CNT_W'(2) || div_done) n_state = lhrs_pkg::ST_SQRT;
            end
            lhrs_pkg::ST_SQRT: begin
                if (r_sk == SQ_CW'(lhrs_pkg::SQRT_STEPS - 1)) n_state = lhrs_pkg::ST_DONE;
            end
            lhrs_pkg::ST_DONE:    if (out_free) n_state = lhrs_pkg::ST_IDLE;
            default:              n_state = lhrs_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshakes, divider launch, RAM port and multiplier operands
    always_comb begin
        o_in_ready  = (r_state == lhrs_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        ram_re      = 1'b0;
        ram_raddr   = ram_base + AW'(r_bkt);
        ram_we      = 1'b0;
        ram_waddr   = ram_base + AW'(r_bkt);
        ram_wdata   = bkt_inc;
        mul_a       = {8'b0, d1};
        mul_b       = d2;
        unique case (r_state)
            lhrs_pkg::ST_BDIV: begin
                div_start = !r_div_issued;
                div_num   = DW'(r_x);
                div_den   = DW'({r_bw, 8'b0});
            end
            lhrs_pkg::ST_RAM_RD:  ram_re = 1'b1;
            lhrs_pkg::ST_RAM_RSP: ram_we = (r_req == lhrs_pkg::REQ_ADD);
            lhrs_pkg::ST_MMUL: begin
                mul_a = cur_cnt;
                mul_b = cur_mean;
            end
            lhrs_pkg::ST_MDIV: begin
                div_start = !r_div_issued;
                div_num   = DW'(r_prod) + DW'(r_x);
                div_den   = DW'(cur_cnt) + DW'(1);
            end
            lhrs_pkg::ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = ram_base + AW'(r_clr);
                ram_wdata = '0;
            end
            lhrs_pkg::ST_VDIV: begin
                div_start = !r_div_issued && (cur_cnt >= CNT_W'(2));
                div_num   = cur_sdev;
                div_den   = DW'(cur_cnt) - DW'(1);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lhrs_pkg::ST_IDLE;
            r_bw         <= lhrs_pkg::BUCKET_WIDTH_RST;
            r_chv        <= '0;
            r_ov         <= 1'b0;
            r_div_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bw <= i_cfg_data;
            end
            if (div_start) begin
                r_div_issued <= 1'b1;
            end else if (div_done) begin
                r_div_issued <= 1'b0;
            end
            if (in_acc && i_req_type == lhrs_pkg::REQ_CLR_ALL) begin
                r_chv <= '0;
            end else if (in_acc && i_req_type == lhrs_pkg::REQ_SETUP && ch_ok) begin
                r_chv[ch_idx] <= 1'b1;
            end
            if (r_state == lhrs_pkg::ST_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lhrs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_req    <= lhrs_pkg::t_req'(i_req_type);
                    r_ch     <= ch_idx;
                    r_x      <= i_sample;
                    r_clr    <= '0;
                    r_bcnt   <= '0;
                    r_bkt    <= BK_W'(NUM_BUCKETS - 1);
                    r_zero   <= (i_req_type == lhrs_pkg::REQ_CLR_ALL) || !ch_ok ||
                                (i_req_type != lhrs_pkg::REQ_SETUP && !r_chv[ch_idx]);
                    r_status <= (i_req_type != lhrs_pkg::REQ_CLR_ALL) &&
                                (i_req_type != lhrs_pkg::REQ_SETUP) &&
                                (!ch_ok || !r_chv[ch_idx]);
                    if (i_req_type == lhrs_pkg::REQ_SETUP) begin
                        r_bkt <= '0;
                        if (ch_ok && !r_chv[ch_idx]) begin
                            r_cnt[ch_idx]  <= '0;
                            r_mean[ch_idx] <= '0;
                            r_sdev[ch_idx] <= '0;
                        end
                    end else if (i_req_type == lhrs_pkg::REQ_READ) begin
                        if (32'(i_bucket_select) < 32'(NUM_BUCKETS)) begin
                            r_bkt <= BK_W'(i_bucket_select);
                        end
                    end
                end
            end
            lhrs_pkg::ST_BDIV: begin
                if (div_done && div_quo < DW'(NUM_BUCKETS - 1)) begin
                    r_bkt <= BK_W'(div_quo);
                end
            end
            lhrs_pkg::ST_RAM_RSP: begin
                r_bcnt <= (r_req == lhrs_pkg::REQ_ADD) ? bkt_inc : ram_rdata;
            end
            lhrs_pkg::ST_MMUL:  r_prod <= mul_a * mul_b;
            lhrs_pkg::ST_MDIV:  if (div_done) r_nm <= div_quo[SMP_W-1:0];
            lhrs_pkg::ST_SQMUL: r_prod <= mul_a * mul_b;
            lhrs_pkg::ST_UPD: begin
                if (cur_cnt == '0) begin
                    r_mean[r_ch] <= r_x;
                    r_sdev[r_ch] <= '0;
                end else begin
                    r_mean[r_ch] <= r_nm;
                    r_sdev[r_ch] <= s_sum[SD_W] ? '1 : s_sum[SD_W-1:0];
                end
                if (cur_cnt != '1) r_cnt[r_ch] <= cur_cnt + 1'b1;
            end
            lhrs_pkg::ST_CLR:   r_clr <= r_clr + 1'b1;
            lhrs_pkg::ST_VDIV: begin
                // Seed the square root with whichever variance applies
                r_sres <= '0;
                r_sbit <= VAR_W'(1) << (VAR_W - 2);
                r_sk   <= '0;
                if (cur_cnt < CNT_W'(2)) begin
                    r_var <= '0;
                    r_sv  <= '0;
                end else if (div_done) begin
                    r_var <= (div_quo[DW-1:VAR_W] != '0) ? '1 : div_quo[VAR_W-1:0];
                    r_sv  <= (div_quo[DW-1:VAR_W] != '0) ? '1 : div_quo[VAR_W-1:0];
                end
            end
            lhrs_pkg::ST_SQRT: begin
                if ({1'b0, r_sv} >= sq_t) begin
                    r_sv   <= r_sv - sq_t[VAR_W-1:0];
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_sk   <= r_sk + 1'b1;
            end
            lhrs_pkg::ST_DONE: begin
                if (out_free) begin
                    r_o_status <= r_status;
                    r_o_cnt    <= r_zero ? '0 : cur_cnt;
                    r_o_mean   <= r_zero ? '0 : cur_mean;
                    r_o_var    <= r_zero ? '0 : r_var;
                    r_o_sd     <= r_zero ? '0 : r_sres[SMP_W-1:0];
                    r_o_bidx   <= r_zero ? '0 : bkt_ext[6:0];
                    r_o_bcnt   <= r_zero ? '0 : r_bcnt;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_sample_count = r_o_cnt;
    assign o_mean         = r_o_mean;
    assign o_variance     = r_o_var;
    assign o_std_dev      = r_o_sd;
    assign o_bucket_index = r_o_bidx;
    assign o_bucket_count = r_o_bcnt;

    // Clear all drops every channel
    a_clr_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == lhrs_pkg::REQ_CLR_ALL) |=> (r_chv == '0))
        else $error("channel still valid after clear all");

    // Divider results only arrive while a division state waits for them
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == lhrs_pkg::ST_BDIV || r_state == lhrs_pkg::ST_MDIV ||
                      r_state == lhrs_pkg::ST_VDIV))
        else $error("divider finished outside a division state");

    // Launch a division only on an idle divider
    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("division launched while the divider is busy");

    // Sweep writes zeros into the histogram row
    a_clr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lhrs_pkg::ST_CLR) |-> (ram_we && ram_wdata == '0))
        else $error("histogram sweep not writing zero");

    // No new request while one is in flight
    a_one_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lhrs_pkg::ST_IDLE) |-> !o_in_ready)
        else $error("request accepted while busy");
endmodule
